### hdl/fpmt_pkg.sv
// Shared types and command codes for the fixed-point matrix transform unit.
package fpmt_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int MAT_N  = 16;
    localparam int PROD_W = 2 * DATA_W;
    // three full products plus a shifted row term need two guard bits
    localparam int SUM_W  = PROD_W + 2;

    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam cmd_t CMD_IDENTITY  = 3'd0;
    localparam cmd_t CMD_TRANSLATE = 3'd1;
    localparam cmd_t CMD_SCALE     = 3'd2;
    localparam cmd_t CMD_TRANSFORM = 3'd3;
    localparam cmd_t CMD_READ      = 3'd4;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

endpackage

### hdl/fpmt_finish.sv
// Fixed-point sum finishing: shift right toward zero and saturate to 32 bits.
module fpmt_finish #(
    parameter int FRAC_BITS = 16
) (
    input  fpmt_pkg::sum_t  sum_in,
    output fpmt_pkg::word_t word_out
);
    import fpmt_pkg::*;

    localparam sum_t BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

    sum_t                    biased;
    sum_t                    quot;
    logic [SUM_W-DATA_W:0]   upper;
    logic                    fits;

    always_comb begin
        // bias negative sums so the arithmetic shift truncates toward zero
        biased   = sum_in + (sum_in[SUM_W-1] ? BIAS : '0);
        quot     = biased >>> FRAC_BITS;
        upper    = quot[SUM_W-1:DATA_W-1];
        fits     = (&upper) || !(|upper);
        if (fits) begin
            word_out = quot[DATA_W-1:0];
        end else if (quot[SUM_W-1]) begin
            word_out = WORD_MIN;
        end else begin
            word_out = WORD_MAX;
        end
    end

endmodule

### hdl/fixed_point_matrix_transform_unit.sv
// Top level of the fixed-point 4x4 modelview matrix transform unit.
// Holds a 4x4 matrix of signed fixed-point words (FRAC_BITS fraction bits),
// identity after reset. A request is taken into an input register; from there
// one pass of twelve 32x32 multipliers, the row sums and the shift and
// saturation updates the matrix and loads any result into the result register,
// which drives m_valid. Requests of every kind, updates included, stream at one
// per cycle, and the next request sees the matrix left by the one before it.
// The input stalls only while a transform or read waits on a full result
// register that m_ready does not drain. Identity, translate, scale and codes 5
// to 7 return no result; a transform result carries zero in element_value, a
// read result carries zero in out_x, out_y and out_z.
module fixed_point_matrix_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fpmt_pkg::cmd_t   s_command,
    input  fpmt_pkg::word_t  s_x_val,
    input  fpmt_pkg::word_t  s_y_val,
    input  fpmt_pkg::word_t  s_z_val,
    input  fpmt_pkg::idx_t   s_element_index,
    output logic             m_valid,
    input  logic             m_ready,
    output fpmt_pkg::word_t  m_out_x,
    output fpmt_pkg::word_t  m_out_y,
    output fpmt_pkg::word_t  m_out_z,
    output fpmt_pkg::word_t  m_element_value
);
    import fpmt_pkg::*;

    localparam word_t ONE_FIX = DATA_W'(1) << FRAC_BITS;

    word_t mat_reg [MAT_N];

    // input stage
    logic  a_valid_reg;
    cmd_t  a_cmd_reg;
    word_t a_op_reg [3];
    idx_t  a_idx_reg;

    prod_t prod [3][4];

    // result register
    logic  m_valid_reg;
    word_t out_x_reg, out_y_reg, out_z_reg, elem_reg;

    sum_t  fin_in [3][4];
    word_t fin_out [3][4];

    logic  out_free, a_out, a_go, a_free, s_take;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        a_out    = (a_cmd_reg == CMD_TRANSFORM) || (a_cmd_reg == CMD_READ);
        // hold a transform or read while the result register stays full
        a_go     = a_valid_reg && (!a_out || out_free);
        a_free   = !a_valid_reg || a_go;
        s_ready  = a_free;
        s_take   = s_valid && a_free;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                prod[r][c] = PROD_W'(a_op_reg[r]) * PROD_W'(mat_reg[r*4 + c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (a_cmd_reg == CMD_SCALE) begin
                fin_in[0][c] = SUM_W'(prod[0][c]);
            end else begin
                fin_in[0][c] = SUM_W'(prod[0][c]) + SUM_W'(prod[1][c])
                               + SUM_W'(prod[2][c])
                               + ((a_cmd_reg == CMD_TRANSLATE)
                                  ? (SUM_W'(mat_reg[12 + c]) <<< FRAC_BITS) : '0);
            end
            fin_in[1][c] = SUM_W'(prod[1][c]);
            fin_in[2][c] = SUM_W'(prod[2][c]);
        end
    end

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 4; gc++) begin : g_col
            fpmt_finish #(
                .FRAC_BITS (FRAC_BITS)
            ) u_finish (
                .sum_in   (fin_in[gr][gc]),
                .word_out (fin_out[gr][gc])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= s_valid;
            end
            if (a_go && a_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_cmd_reg   <= s_command;
            a_op_reg[0] <= s_x_val;
            a_op_reg[1] <= s_y_val;
            a_op_reg[2] <= s_z_val;
            a_idx_reg   <= s_element_index;
        end
        if (a_go && a_out) begin
            if (a_cmd_reg == CMD_TRANSFORM) begin
                out_x_reg <= fin_out[0][0];
                out_y_reg <= fin_out[0][1];
                out_z_reg <= fin_out[0][2];
                elem_reg  <= '0;
            end else begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
                elem_reg  <= mat_reg[a_idx_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAT_N; i++) begin
                mat_reg[i] <= (i % 5 == 0) ? ONE_FIX : '0;
            end
        end else if (a_go) begin
            case (a_cmd_reg)
                CMD_IDENTITY: begin
                    for (int i = 0; i < MAT_N; i++) begin
                        mat_reg[i] <= (i % 5 == 0) ? ONE_FIX : '0;
                    end
                end
                CMD_TRANSLATE: begin
                    for (int c = 0; c < 4; c++) begin
                        mat_reg[12 + c] <= fin_out[0][c];
                    end
                end
                CMD_SCALE: begin
                    for (int r = 0; r < 3; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            mat_reg[r*4 + c] <= fin_out[r][c];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = out_x_reg;
    assign m_out_y         = out_y_reg;
    assign m_out_z         = out_z_reg;
    assign m_element_value = elem_reg;

endmodule
